/* design/wildcard_pattern_matcher_top_macros.svh */
// ----------------------------------------------------------------------------
// Wildcard pattern matcher assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_PATTERN_MATCHER_TOP_MACROS_SVH
`define WILDCARD_PATTERN_MATCHER_TOP_MACROS_SVH

// same-cycle implication
`define WPM_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wpm: same-cycle check failed");

// next-cycle implication
`define WPM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wpm: next-cycle check failed");

`endif

/* design/wpm_pkg.sv */
// ----------------------------------------------------------------------------
// Wildcard pattern matcher package
// Shared constants, operation codes and the token that walks the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

   localparam int unsigned DEFAULT_PATTERN_DEPTH = 32;

   localparam logic [7:0] SYM_STAR = 8'd42;
   localparam logic [7:0] SYM_ANY  = 8'd63;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_APPEND  = 2'd1,
      OP_TEXT    = 2'd2,
      OP_RESTART = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_BUSY = 1'b1
   } state_type;

   // wave that visits one cell per cycle
   typedef struct packed {
      logic       valid;
      logic       text;     // 1: text byte, 0: rebuild for empty text
      logic       active;   // cleared once the last pattern cell is updated
      logic [7:0] sym;
      logic       new_bit;  // new match bit of the previous prefix
      logic       old_bit;  // old match bit of the previous prefix
   } token_type;

   typedef struct packed {
      logic       en;
      logic [7:0] data;
   } pat_wr_type;

   typedef struct packed {
      logic busy;
      logic pattern_full;
   } status_type;

endpackage

`default_nettype wire

/* design/wpm_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one operation and its symbol per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] symbol;

   modport source (output valid, output operation, output symbol, input ready);
   modport sink   (input valid, input operation, input symbol, output ready);
endinterface

`default_nettype wire

/* design/wpm_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the match flag and overflow flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpm_rsp_if;
   logic valid;
   logic ready;
   logic whole_match;
   logic pattern_overflow;

   modport source (output valid, output whole_match, output pattern_overflow,
                   input ready);
   modport sink   (input valid, input whole_match, input pattern_overflow,
                   output ready);
endinterface

`default_nettype wire

/* design/wpm_cell.sv */
// ----------------------------------------------------------------------------
// Pattern cell
// Holds one pattern byte and the match bit of its prefix; updates the bit
// when the wave passes and hands the wave to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_cell #(
   parameter int unsigned PATTERN_DEPTH = wpm_pkg::DEFAULT_PATTERN_DEPTH,
   parameter int unsigned CELL_INDEX    = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  wpm_pkg::token_type                   tok_i,
   input  wpm_pkg::pat_wr_type                  pat_wr,
   input  logic [$clog2(PATTERN_DEPTH+1)-1:0]   pattern_length,
   output wpm_pkg::token_type                   tok_o
);
   import wpm_pkg::*;

   localparam int unsigned     LEN_W    = $clog2(PATTERN_DEPTH + 1);
   localparam logic [LEN_W-1:0] MY_INDEX = LEN_W'(CELL_INDEX);
   localparam logic [LEN_W-1:0] WR_INDEX = LEN_W'(CELL_INDEX - 1);

   logic [7:0] pat_byte_ff;
   logic       match_ff;
   logic       match_in;
   token_type  tok_ff;
   token_type  tok_in;
   logic       is_star;
   logic       is_hit;
   logic       work;

   always_comb begin
      is_star  = (pat_byte_ff == SYM_STAR);
      is_hit   = (pat_byte_ff == tok_i.sym) || (pat_byte_ff == SYM_ANY);
      work     = tok_i.valid && tok_i.active;
      match_in = match_ff;
      tok_in   = tok_i;
      if (work) begin
         if (tok_i.text) begin
            if (is_star) begin
               match_in = tok_i.new_bit | match_ff;
            end else if (is_hit) begin
               match_in = tok_i.old_bit;
            end else begin
               match_in = 1'b0;
            end
         end else begin
            match_in = tok_i.new_bit & is_star;
         end
         tok_in.new_bit = match_in;
         tok_in.old_bit = match_ff;
         // stop updating past the end of the pattern
         tok_in.active  = (pattern_length != MY_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (pat_wr.en && (pattern_length == WR_INDEX)) begin
         pat_byte_ff <= pat_wr.data;
      end
      match_ff <= match_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

`default_nettype wire

/* design/wpm_ctrl.sv */
// ----------------------------------------------------------------------------
// Matcher controller
// Takes request beats, keeps the pattern length, launches the wave into the
// cell chain and returns the match flag from the chain tail.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_ctrl #(
   parameter int unsigned PATTERN_DEPTH = wpm_pkg::DEFAULT_PATTERN_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   wpm_req_if.sink                              req,
   wpm_rsp_if.source                            rsp,
   output wpm_pkg::token_type                   inject_o,
   input  wpm_pkg::token_type                   tail_i,
   output wpm_pkg::pat_wr_type                  pat_wr,
   output logic [$clog2(PATTERN_DEPTH+1)-1:0]   pattern_length,
   output wpm_pkg::status_type                  status
);
   import wpm_pkg::*;

   localparam int unsigned LEN_W = $clog2(PATTERN_DEPTH + 1);

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             bit0_ff, bit0_in;
   logic             cur_match_ff, cur_match_in;
   token_type        inject_ff, inject_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             whole_ff, whole_in;
   logic             ovf_ff, ovf_in;
   op_type           op;
   logic             full;
   logic             accept;
   logic             start;

   assign op        = op_type'(req.operation);
   assign full      = (len_ff == LEN_W'(PATTERN_DEPTH));
   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      bit0_in      = bit0_ff;
      cur_match_in = cur_match_ff;
      inject_in    = '0;
      pat_wr.en    = 1'b0;
      pat_wr.data  = req.symbol;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      whole_in     = whole_ff;
      ovf_in       = ovf_ff;
      start        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (op) inside
                  OP_CLEAR: begin
                     len_in = '0;
                     start  = 1'b1;
                  end
                  OP_APPEND: begin
                     if (full) begin
                        // refused append: answer at once, state untouched
                        rsp_valid_in = 1'b1;
                        whole_in     = cur_match_ff;
                        ovf_in       = 1'b1;
                     end else begin
                        pat_wr.en = 1'b1;
                        len_in    = len_ff + LEN_W'(1);
                        start     = 1'b1;
                     end
                  end
                  OP_TEXT, OP_RESTART: begin
                     start = 1'b1;
                  end
                  default: begin
                     start = 1'b0;
                  end
               endcase
               if (start) begin
                  inject_in.valid   = 1'b1;
                  inject_in.text    = (op == OP_TEXT);
                  inject_in.sym     = req.symbol;
                  inject_in.active  = (len_in != '0);
                  inject_in.new_bit = (op != OP_TEXT);
                  inject_in.old_bit = bit0_ff;
                  bit0_in           = (op != OP_TEXT);
                  state_in          = ST_BUSY;
               end
            end
         end
         ST_BUSY: begin
            if (tail_i.valid) begin
               rsp_valid_in = 1'b1;
               whole_in     = tail_i.new_bit;
               ovf_in       = 1'b0;
               cur_match_in = tail_i.new_bit;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         len_ff          <= '0;
         bit0_ff         <= 1'b1;
         cur_match_ff    <= 1'b1;
         inject_ff.valid <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         bit0_ff      <= bit0_in;
         cur_match_ff <= cur_match_in;
         inject_ff    <= inject_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      whole_ff <= whole_in;
      ovf_ff   <= ovf_in;
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.whole_match      = whole_ff;
   assign rsp.pattern_overflow = ovf_ff;

   assign inject_o            = inject_ff;
   assign pattern_length      = len_ff;
   assign status.busy         = (state_ff == ST_BUSY);
   assign status.pattern_full = full;

endmodule

`default_nettype wire

/* design/wildcard_pattern_matcher_top.sv */
// ----------------------------------------------------------------------------
// Wildcard pattern matcher
// Streams text bytes against a stored pattern with '*' and '?' wildcards.
// ----------------------------------------------------------------------------
// Every accepted beat returns one response beat. Clear, accepted append,
// restart and text beats each send a wave down a chain of PATTERN_DEPTH
// cells, one cell per cycle, and the block takes no new beat until that
// wave has left the chain tail. An append to a full pattern is answered in
// the next cycle with pattern_overflow set. A finished response sits in an
// output register, and a new beat is taken once that register is free or
// being emptied.
`default_nettype none

`include "wildcard_pattern_matcher_top_macros.svh"

module wildcard_pattern_matcher_top #(
   parameter int unsigned PATTERN_DEPTH = wpm_pkg::DEFAULT_PATTERN_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   wpm_req_if.sink   req_bus,
   wpm_rsp_if.source rsp_bus
);
   import wpm_pkg::*;

   localparam int unsigned LEN_W = $clog2(PATTERN_DEPTH + 1);

   token_type        chain_tok [PATTERN_DEPTH+1];
   pat_wr_type       pat_wr;
   logic [LEN_W-1:0] pattern_length;
   status_type       status;
   logic             req_fire;
   logic             rsp_free;
   logic             tail_valid;
   logic             full_append;
   logic             rsp_ovf;

   wpm_ctrl #(
      .PATTERN_DEPTH (PATTERN_DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req            (req_bus),
      .rsp            (rsp_bus),
      .inject_o       (chain_tok[0]),
      .tail_i         (chain_tok[PATTERN_DEPTH]),
      .pat_wr         (pat_wr),
      .pattern_length (pattern_length),
      .status         (status)
   );

   for (genvar k = 1; k <= PATTERN_DEPTH; k++) begin : g_cell
      wpm_cell #(
         .PATTERN_DEPTH (PATTERN_DEPTH),
         .CELL_INDEX    (k)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .tok_i          (chain_tok[k-1]),
         .pat_wr         (pat_wr),
         .pattern_length (pattern_length),
         .tok_o          (chain_tok[k])
      );
   end

   assign req_fire    = req_bus.valid && req_bus.ready;
   assign rsp_free    = !rsp_bus.valid || rsp_bus.ready;
   assign tail_valid  = chain_tok[PATTERN_DEPTH].valid;
   assign full_append = req_fire && (req_bus.operation == OP_APPEND) && status.pattern_full;
   assign rsp_ovf     = rsp_bus.valid && rsp_bus.pattern_overflow;

   `WPM_ASSERT_IMPL(a_no_accept_on_stall, clock, reset, req_fire, rsp_free)
   `WPM_ASSERT_IMPL(a_busy_blocks_req, clock, reset, status.busy, !req_bus.ready)
   `WPM_ASSERT_IMPL(a_tail_only_when_busy, clock, reset, tail_valid, status.busy)
   `WPM_ASSERT_NEXT(a_full_append_flags, clock, reset, full_append, rsp_ovf)

endmodule

`default_nettype wire

/* sim/wildcard_pattern_matcher_top_test.sv */
// ----------------------------------------------------------------------------
// Wildcard pattern matcher testbench
// Loads patterns built from stars, question marks and plain bytes, streams
// text that mostly fits them, and checks every response beat against a
// prefix-match predictor kept here. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_pattern_matcher_top_test;
   import wpm_pkg::*;

   localparam int unsigned DEPTH      = DEFAULT_PATTERN_DEPTH;
   localparam int unsigned ITEM_GOAL  = 1500;
   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned TAIL_WAIT  = DEPTH + 10;

   // Tracks the pattern and one match bit per prefix, and queues the
   // response each accepted request should produce.
   class match_book_type;
      typedef struct packed {
         logic whole_match;
         logic pattern_overflow;
      } match_flags_type;

      logic [7:0]      pattern [DEPTH];
      int unsigned     pat_len;
      bit [DEPTH:0]    prefix_bits;
      match_flags_type flags_q [$];
      int unsigned     mismatches;

      function new();
         foreach (pattern[i]) pattern[i] = 8'd0;
         pat_len     = 0;
         prefix_bits = '0;
         prefix_bits[0] = 1'b1;
         mismatches  = 0;
      endfunction

      // empty text: prefix i matches only when it is all stars
      function void rebuild_empty();
         prefix_bits = '0;
         prefix_bits[0] = 1'b1;
         for (int unsigned i = 1; i <= pat_len; i++)
            prefix_bits[i] = prefix_bits[i-1] && (pattern[i-1] == SYM_STAR);
      endfunction

      function void take_text(logic [7:0] sym);
         bit prev_old;
         bit old_bit;
         logic [7:0] p;
         prev_old = prefix_bits[0];
         prefix_bits[0] = 1'b0;
         for (int unsigned i = 1; i <= pat_len; i++) begin
            p = pattern[i-1];
            old_bit = prefix_bits[i];
            if (p == SYM_STAR)
               prefix_bits[i] = prefix_bits[i-1] | old_bit;
            else if (p == sym || p == SYM_ANY)
               prefix_bits[i] = prev_old;
            else
               prefix_bits[i] = 1'b0;
            prev_old = old_bit;
         end
      endfunction

      function void note_request(op_type op, logic [7:0] sym);
         match_flags_type flags;
         flags.pattern_overflow = 1'b0;
         case (op)
            OP_CLEAR: begin
               pat_len = 0;
               rebuild_empty();
            end
            OP_APPEND: begin
               if (pat_len >= DEPTH) begin
                  flags.pattern_overflow = 1'b1;
               end else begin
                  pattern[pat_len] = sym;
                  pat_len++;
                  rebuild_empty();
               end
            end
            OP_TEXT: take_text(sym);
            default: rebuild_empty();
         endcase
         flags.whole_match = prefix_bits[pat_len];
         flags_q.push_back(flags);
      endfunction

      function void check_response(logic whole_match, logic pattern_overflow);
         match_flags_type want;
         if (flags_q.size() == 0) begin
            $error("response beat with no request outstanding");
            mismatches++;
            return;
         end
         want = flags_q.pop_front();
         if (whole_match !== want.whole_match) begin
            $error("whole_match: expected %0d, actual %0d",
                   want.whole_match, whole_match);
            mismatches++;
         end
         if (pattern_overflow !== want.pattern_overflow) begin
            $error("pattern_overflow: expected %0d, actual %0d",
                   want.pattern_overflow, pattern_overflow);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return flags_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   wpm_req_if req_bus ();
   wpm_rsp_if rsp_bus ();

   match_book_type book = new();

   int unsigned items_sent = 0;
   int unsigned burst_left = 0;
   int unsigned idle_cycles = 0;

   wildcard_pattern_matcher_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- driving

   task automatic send_beat(op_type op, logic [7:0] sym);
      if (burst_left == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
      end
      req_bus.valid     = 1'b1;
      req_bus.operation = op;
      req_bus.symbol    = sym;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      book.note_request(op, sym);
      items_sent++;
      @(negedge clock);
      burst_left--;
   endtask

   // hold off until every outstanding response has come back
   task automatic drain();
      req_bus.valid = 1'b0;
      burst_left = 0;
      while (book.pending() != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_pattern_byte();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) return "a";
      if (roll < 35) return "b";
      if (roll < 55) return SYM_STAR;
      if (roll < 70) return SYM_ANY;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pick_text_byte();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) return "a";
      if (roll < 50) return "b";
      if (roll < 58) return SYM_STAR;
      if (roll < 64) return SYM_ANY;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic directed_part();
      send_beat(OP_TEXT, "a");       // empty pattern, nonempty text
      send_beat(OP_RESTART, 8'hff);  // empty pattern, empty text again
      send_beat(OP_APPEND, SYM_STAR);
      send_beat(OP_TEXT, SYM_STAR);  // star in text is a plain byte
      send_beat(OP_TEXT, 8'hff);
      send_beat(OP_APPEND, SYM_ANY);
      send_beat(OP_TEXT, 8'h00);
      send_beat(OP_TEXT, 8'h00);
      send_beat(OP_RESTART, 8'h00);
      send_beat(OP_CLEAR, 8'hff);
      send_beat(OP_APPEND, "a");
      send_beat(OP_APPEND, 8'hff);
      send_beat(OP_TEXT, "a");
      send_beat(OP_TEXT, 8'hff);
      send_beat(OP_TEXT, SYM_STAR);
      send_beat(OP_RESTART, 8'h55);
      send_beat(OP_TEXT, 8'h00);
      send_beat(OP_CLEAR, 8'h00);
      send_beat(OP_APPEND, SYM_ANY);  // question mark vs a literal star
      send_beat(OP_TEXT, SYM_STAR);
      send_beat(OP_TEXT, SYM_ANY);
      drain();
   endtask

   // fill the store, then push appends past the end
   task automatic full_store_part();
      send_beat(OP_CLEAR, 8'($urandom_range(0, 255)));
      for (int unsigned i = 0; i < DEPTH; i++)
         send_beat(OP_APPEND, (i % 5 == 0) ? SYM_STAR : pick_pattern_byte());
      repeat (2) send_beat(OP_APPEND, 8'($urandom_range(0, 255)));
      repeat (40) send_beat(OP_TEXT, pick_text_byte());
      send_beat(OP_APPEND, "a");
   endtask

   task automatic pattern_sequence();
      logic [7:0]  pat [$];
      logic [7:0]  txt [$];
      int unsigned plen;
      int unsigned runs;
      int unsigned k;
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, DEPTH)
                                         : $urandom_range(0, 6);
      send_beat(OP_CLEAR, 8'($urandom_range(0, 255)));
      for (int unsigned i = 0; i < plen; i++) begin
         pat.push_back(pick_pattern_byte());
         send_beat(OP_APPEND, pat[i]);
      end
      if (plen == DEPTH && $urandom_range(0, 1) == 1)
         send_beat(OP_APPEND, pick_pattern_byte());
      runs = $urandom_range(1, 3);
      for (int unsigned r = 0; r < runs; r++) begin
         if (r != 0 || $urandom_range(0, 3) == 0)
            send_beat(OP_RESTART, 8'($urandom_range(0, 255)));
         txt.delete();
         foreach (pat[i]) begin
            if (pat[i] == SYM_STAR)
               repeat ($urandom_range(0, 3)) txt.push_back(pick_text_byte());
            else if (pat[i] == SYM_ANY)
               txt.push_back(8'($urandom_range(0, 255)));
            else
               txt.push_back(pat[i]);
         end
         // break the fit now and then
         case ($urandom_range(0, 7))
            0: if (txt.size() != 0) begin
               k = $urandom_range(0, txt.size() - 1);
               txt[k] = pick_text_byte();
            end
            1: if (txt.size() != 0) void'(txt.pop_back());
            2: txt.push_back(pick_text_byte());
            default: ;
         endcase
         foreach (txt[i]) send_beat(OP_TEXT, txt[i]);
      end
   endtask

   task automatic noise_sequence();
      repeat ($urandom_range(5, 15))
         send_beat(op_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
   endtask

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_CLEAR;
      req_bus.symbol    = 8'd0;
      rsp_bus.ready     = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      directed_part();
      full_store_part();
      drain();
      while (items_sent < ITEM_GOAL) begin
         if ($urandom_range(0, 4) == 0)
            noise_sequence();
         else
            pattern_sequence();
         if ($urandom_range(0, 11) == 0)
            drain();
      end
      req_bus.valid = 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (book.mismatches == 0)
         $display("wildcard_pattern_matcher_top verification clean");
      else
         $display("wildcard_pattern_matcher_top verification failed");
      $finish;
   end

   // --------------------------------------------------------------- receiver

   int unsigned stall_mode  = 0;
   int unsigned mode_left   = 0;
   int unsigned stall_left  = 0;
   int unsigned phase_count = 0;

   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      phase_count++;
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= 1'($urandom_range(0, 1));
         2: rsp_bus.ready <= (phase_count % 4 == 0);
         default: begin
            // long stalls broken by a single open cycle
            if (stall_left == 0) begin
               stall_left = $urandom_range(5, 20);
               rsp_bus.ready <= 1'b1;
            end else begin
               stall_left--;
               rsp_bus.ready <= 1'b0;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         book.check_response(rsp_bus.whole_match, rsp_bus.pattern_overflow);
   end

   // --------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("wildcard_pattern_matcher_top verification failed");
         $finish;
      end
   end

endmodule

`default_nettype wire
